FILE: rtl/sorted_line_cache_with_age_expiry_assert.svh
// Assertion macros used by the line cache checker.
`ifndef SORTED_LINE_CACHE_WITH_AGE_EXPIRY_ASSERT_SVH
`define SORTED_LINE_CACHE_WITH_AGE_EXPIRY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLCAE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLCAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/slcae_pkg.sv
// Package with types, constants and command codes of the sorted line cache.
`timescale 1ns / 1ps
package slcae_pkg;

  localparam int unsigned NumLinesDef  = 40;
  localparam int unsigned LineBytesDef = 2048;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned LenW         = 12;
  localparam int unsigned IdxOutW      = 6;
  localparam int unsigned OffW         = 11;
  localparam int unsigned CntOutW      = 6;
  localparam int unsigned StaleW       = 8;
  localparam int unsigned StampW       = 32;
  localparam logic [StaleW-1:0] StaleResetVal = 8'd6;

  typedef struct packed {
    logic              kind;
    logic [AddrW-1:0]  source_address;
    logic [LenW-1:0]   range_length;
  } in_req_t;

  typedef struct packed {
    logic               hit;
    logic [IdxOutW-1:0] line_index;
    logic [OffW-1:0]    line_offset;
    logic               fill_request;
    logic [AddrW-1:0]   fill_address;
    logic               no_free_line;
    logic [CntOutW-1:0] released_count;
  } out_rsp_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_START,
    OP_READ_CUR,
    OP_LCHECK,
    OP_NOFREE,
    OP_READ_FREE,
    OP_MDETACH,
    OP_READ_AFTER,
    OP_MLINK_A,
    OP_MLINK_B,
    OP_MFRONT_A,
    OP_MFRONT_B,
    OP_TFINISH,
    OP_TCHECK,
    OP_TLINK_A,
    OP_TLINK_B,
    OP_TPARK
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_none;
    logic steps_done;
    logic free_none;
    logic after_none;
    logic beyond;
    logic covers;
    logic stale;
  } dp_status_t;

endpackage

FILE: rtl/slcae_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module slcae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/slcae_ctrl.sv
// Controller state machine that sequences list walks and link updates.
`timescale 1ns / 1ps
module slcae_ctrl import slcae_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       kind_i,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE        = 17'h00001,
    S_LREAD       = 17'h00002,
    S_LCHECK      = 17'h00004,
    S_MISS        = 17'h00008,
    S_MDETACH     = 17'h00010,
    S_MREAD_AFTER = 17'h00020,
    S_MLINK_A     = 17'h00040,
    S_MLINK_B     = 17'h00080,
    S_MFRONT_A    = 17'h00100,
    S_MFRONT_B    = 17'h00200,
    S_TREAD       = 17'h00400,
    S_TCHECK      = 17'h00800,
    S_TREAD_FREE  = 17'h01000,
    S_TLINK_A     = 17'h02000,
    S_TLINK_B     = 17'h04000,
    S_TPARK       = 17'h08000,
    S_DONE        = 17'h10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.op       = OP_NOP;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_START;
          state_d  = kind_i ? S_TREAD : S_LREAD;
        end
      end
      S_LREAD: begin
        if (status_i.cur_none || status_i.steps_done) begin
          state_d = S_MISS;
        end else begin
          cmd_o.op = OP_READ_CUR;
          state_d  = S_LCHECK;
        end
      end
      S_LCHECK: begin
        cmd_o.op = OP_LCHECK;
        if (status_i.beyond) begin
          state_d = S_MISS;
        end else if (status_i.covers) begin
          state_d = S_DONE;
        end else begin
          state_d = S_LREAD;
        end
      end
      S_MISS: begin
        if (status_i.free_none) begin
          cmd_o.op = OP_NOFREE;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_READ_FREE;
          state_d  = S_MDETACH;
        end
      end
      S_MDETACH: begin
        cmd_o.op = OP_MDETACH;
        state_d  = status_i.after_none ? S_MFRONT_A : S_MREAD_AFTER;
      end
      S_MREAD_AFTER: begin
        cmd_o.op = OP_READ_AFTER;
        state_d  = S_MLINK_A;
      end
      S_MLINK_A: begin
        cmd_o.op = OP_MLINK_A;
        state_d  = S_MLINK_B;
      end
      S_MLINK_B: begin
        cmd_o.op = OP_MLINK_B;
        state_d  = S_DONE;
      end
      S_MFRONT_A: begin
        cmd_o.op = OP_MFRONT_A;
        state_d  = S_MFRONT_B;
      end
      S_MFRONT_B: begin
        cmd_o.op = OP_MFRONT_B;
        state_d  = S_DONE;
      end
      S_TREAD: begin
        if (status_i.cur_none || status_i.steps_done) begin
          cmd_o.op = OP_TFINISH;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_READ_CUR;
          state_d  = S_TCHECK;
        end
      end
      S_TCHECK: begin
        cmd_o.op = OP_TCHECK;
        if (status_i.stale) begin
          state_d = status_i.free_none ? S_TPARK : S_TREAD_FREE;
        end else begin
          state_d = S_TREAD;
        end
      end
      S_TREAD_FREE: begin
        cmd_o.op = OP_READ_FREE;
        state_d  = S_TLINK_A;
      end
      S_TLINK_A: begin
        cmd_o.op = OP_TLINK_A;
        state_d  = S_TLINK_B;
      end
      S_TLINK_B: begin
        cmd_o.op = OP_TLINK_B;
        state_d  = S_TREAD;
      end
      S_TPARK: begin
        cmd_o.op = OP_TPARK;
        state_d  = S_TREAD;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/slcae_dp.sv
// Datapath: line memories, list pointers, frame counter and result registers.
`timescale 1ns / 1ps
module slcae_dp import slcae_pkg::*; #(
  parameter int unsigned NUM_LINES  = NumLinesDef,
  parameter int unsigned LINE_BYTES = LineBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  in_req_t           in_req_i,
  input  logic              cfg_we_i,
  input  logic [StaleW-1:0] cfg_wdata_i,
  output dp_status_t        status_o,
  output out_rsp_t          out_rsp_o
);

  localparam int unsigned AW = $clog2(NUM_LINES);
  localparam int unsigned IW = $clog2(NUM_LINES + 1);
  localparam logic [IW-1:0] NoneIdx = IW'(NUM_LINES);

  // Request and walk registers
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [AddrW:0]    want_end_q, want_end_d;
  logic [IW-1:0]     cur_q, cur_d, after_q, after_d, s_q, s_d;
  logic [IW-1:0]     n_q, n_d, n2_q, n2_d, steps_q, steps_d, released_q, released_d;
  logic [IW-1:0]     used_head_q, used_head_d, free_head_q, free_head_d;
  logic [StampW-1:0] frame_q, frame_d;
  logic [StaleW-1:0] stale_q, stale_d;
  out_rsp_t          res_q, res_d, out_q;

  // Memory ports
  logic              rd_en;
  logic [AW-1:0]     rd_addr, rd_addr_q;
  logic              start_we, stamp_we, nxt_we, prv_we;
  logic [AW-1:0]     start_waddr, stamp_waddr, nxt_waddr, prv_waddr;
  logic [AddrW-1:0]  start_wdata, ram_start;
  logic [StampW-1:0] stamp_wdata, ram_stamp;
  logic [IW-1:0]     nxt_wdata, prv_wdata, ram_next, ram_prev;
  logic [NUM_LINES-1:0] nvld_q, pvld_q;
  logic              rd_nvld_q, rd_pvld_q;
  logic [IW-1:0]     rd_next, rd_prev;
  logic [AddrW-1:0]  hit_diff;

  slcae_ram #(.WIDTH(AddrW), .DEPTH(NUM_LINES)) u_start_ram (
    .clk_i, .we_i(start_we), .waddr_i(start_waddr), .wdata_i(start_wdata),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(ram_start)
  );
  slcae_ram #(.WIDTH(StampW), .DEPTH(NUM_LINES)) u_stamp_ram (
    .clk_i, .we_i(stamp_we), .waddr_i(stamp_waddr), .wdata_i(stamp_wdata),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(ram_stamp)
  );
  slcae_ram #(.WIDTH(IW), .DEPTH(NUM_LINES)) u_next_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(ram_next)
  );
  slcae_ram #(.WIDTH(IW), .DEPTH(NUM_LINES)) u_prev_ram (
    .clk_i, .we_i(prv_we), .waddr_i(prv_waddr), .wdata_i(prv_wdata),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(ram_prev)
  );

  // Unwritten link entries read as the reset chain
  assign rd_next = rd_nvld_q ? ram_next : IW'(rd_addr_q) + IW'(1);
  assign rd_prev = rd_pvld_q ? ram_prev :
                   ((rd_addr_q == '0) ? NoneIdx : IW'(rd_addr_q) - IW'(1));

  assign hit_diff = addr_q - ram_start;

  assign status_o.cur_none   = (cur_q >= NoneIdx);
  assign status_o.steps_done = (steps_q == NoneIdx);
  assign status_o.free_none  = (free_head_q >= NoneIdx);
  assign status_o.after_none = (after_q >= NoneIdx);
  assign status_o.beyond     = (ram_start > addr_q);
  assign status_o.covers     = (({1'b0, ram_start} + (AddrW+1)'(LINE_BYTES)) >= want_end_q);
  assign status_o.stale      = ((ram_stamp + StampW'(stale_q)) < frame_q);

  always_comb begin
    addr_d      = addr_q;
    want_end_d  = want_end_q;
    cur_d       = cur_q;
    after_d     = after_q;
    s_d         = s_q;
    n_d         = n_q;
    n2_d        = n2_q;
    steps_d     = steps_q;
    released_d  = released_q;
    used_head_d = used_head_q;
    free_head_d = free_head_q;
    frame_d     = frame_q;
    stale_d     = cfg_we_i ? cfg_wdata_i : stale_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = cur_q[AW-1:0];
    start_we    = 1'b0;
    start_waddr = s_q[AW-1:0];
    start_wdata = {addr_q[AddrW-1:1], 1'b0};
    stamp_we    = 1'b0;
    stamp_waddr = s_q[AW-1:0];
    stamp_wdata = frame_q;
    nxt_we      = 1'b0;
    nxt_waddr   = s_q[AW-1:0];
    nxt_wdata   = rd_next;
    prv_we      = 1'b0;
    prv_waddr   = s_q[AW-1:0];
    prv_wdata   = rd_prev;
    case (cmd_i.op)
      OP_START: begin
        addr_d     = in_req_i.source_address;
        want_end_d = {1'b0, in_req_i.source_address} + (AddrW+1)'(in_req_i.range_length);
        cur_d      = used_head_q;
        after_d    = NoneIdx;
        steps_d    = '0;
        released_d = '0;
        res_d      = '0;
      end
      OP_READ_CUR: begin
        rd_en   = 1'b1;
        rd_addr = cur_q[AW-1:0];
      end
      OP_LCHECK: begin
        if (!status_o.beyond) begin
          after_d = cur_q;
          if (status_o.covers) begin
            stamp_we          = 1'b1;
            stamp_waddr       = cur_q[AW-1:0];
            res_d.hit         = 1'b1;
            res_d.line_index  = IdxOutW'(cur_q);
            res_d.line_offset = hit_diff[OffW-1:0];
          end else begin
            cur_d   = rd_next;
            steps_d = steps_q + IW'(1);
          end
        end
      end
      OP_NOFREE: begin
        res_d.no_free_line = 1'b1;
      end
      OP_READ_FREE: begin
        rd_en   = 1'b1;
        rd_addr = free_head_q[AW-1:0];
        s_d     = free_head_q;
      end
      OP_MDETACH: begin
        // Pop the free head and unhook it from its neighbors
        free_head_d = rd_next;
        prv_we      = (rd_next < NoneIdx);
        prv_waddr   = rd_next[AW-1:0];
        prv_wdata   = rd_prev;
        nxt_we      = (rd_prev < NoneIdx);
        nxt_waddr   = rd_prev[AW-1:0];
        nxt_wdata   = rd_next;
      end
      OP_READ_AFTER: begin
        rd_en   = 1'b1;
        rd_addr = after_q[AW-1:0];
      end
      OP_MLINK_A: begin
        n2_d      = rd_next;
        nxt_we    = 1'b1;
        nxt_wdata = rd_next;
        prv_we    = 1'b1;
        prv_wdata = after_q;
        start_we  = 1'b1;
        stamp_we  = 1'b1;
      end
      OP_MLINK_B: begin
        prv_we             = (n2_q < NoneIdx);
        prv_waddr          = n2_q[AW-1:0];
        prv_wdata          = s_q;
        nxt_we             = 1'b1;
        nxt_waddr          = after_q[AW-1:0];
        nxt_wdata          = s_q;
        res_d.line_index   = IdxOutW'(s_q);
        res_d.line_offset  = OffW'(addr_q[0]);
        res_d.fill_request = 1'b1;
        res_d.fill_address = {addr_q[AddrW-1:1], 1'b0};
      end
      OP_MFRONT_A: begin
        nxt_we    = 1'b1;
        nxt_wdata = used_head_q;
        prv_we    = 1'b1;
        prv_wdata = NoneIdx;
        start_we  = 1'b1;
        stamp_we  = 1'b1;
      end
      OP_MFRONT_B: begin
        prv_we             = (used_head_q < NoneIdx);
        prv_waddr          = used_head_q[AW-1:0];
        prv_wdata          = s_q;
        used_head_d        = s_q;
        res_d.line_index   = IdxOutW'(s_q);
        res_d.line_offset  = OffW'(addr_q[0]);
        res_d.fill_request = 1'b1;
        res_d.fill_address = {addr_q[AddrW-1:1], 1'b0};
      end
      OP_TFINISH: begin
        frame_d              = frame_q + StampW'(1);
        res_d.released_count = CntOutW'(released_q);
      end
      OP_TCHECK: begin
        if (status_o.stale) begin
          n_d        = rd_next;
          released_d = released_q + IW'(1);
          if (cur_q == used_head_q) begin
            used_head_d = rd_next;
          end
          prv_we    = (rd_next < NoneIdx);
          prv_waddr = rd_next[AW-1:0];
          prv_wdata = rd_prev;
          nxt_we    = (rd_prev < NoneIdx);
          nxt_waddr = rd_prev[AW-1:0];
          nxt_wdata = rd_next;
        end else begin
          cur_d   = rd_next;
          steps_d = steps_q + IW'(1);
        end
      end
      OP_TLINK_A: begin
        n2_d      = rd_next;
        nxt_we    = 1'b1;
        nxt_waddr = cur_q[AW-1:0];
        nxt_wdata = rd_next;
        prv_we    = 1'b1;
        prv_waddr = cur_q[AW-1:0];
        prv_wdata = free_head_q;
      end
      OP_TLINK_B: begin
        prv_we    = (n2_q < NoneIdx);
        prv_waddr = n2_q[AW-1:0];
        prv_wdata = cur_q;
        nxt_we    = 1'b1;
        nxt_waddr = free_head_q[AW-1:0];
        nxt_wdata = cur_q;
        cur_d     = n_q;
        steps_d   = steps_q + IW'(1);
      end
      OP_TPARK: begin
        free_head_d = cur_q;
        nxt_we      = 1'b1;
        nxt_waddr   = cur_q[AW-1:0];
        nxt_wdata   = NoneIdx;
        prv_we      = 1'b1;
        prv_waddr   = cur_q[AW-1:0];
        prv_wdata   = NoneIdx;
        cur_d       = n_q;
        steps_d     = steps_q + IW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_head_q <= NoneIdx;
      free_head_q <= '0;
      frame_q     <= '0;
      stale_q     <= StaleResetVal;
      nvld_q      <= '0;
      pvld_q      <= '0;
    end else begin
      used_head_q <= used_head_d;
      free_head_q <= free_head_d;
      frame_q     <= frame_d;
      stale_q     <= stale_d;
      if (nxt_we) begin
        nvld_q[nxt_waddr] <= 1'b1;
      end
      if (prv_we) begin
        pvld_q[prv_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    want_end_q <= want_end_d;
    cur_q      <= cur_d;
    after_q    <= after_d;
    s_q        <= s_d;
    n_q        <= n_d;
    n2_q       <= n2_d;
    steps_q    <= steps_d;
    released_q <= released_d;
    res_q      <= res_d;
    if (rd_en) begin
      rd_addr_q <= rd_addr;
      rd_nvld_q <= nvld_q[rd_addr];
      rd_pvld_q <= pvld_q[rd_addr];
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_rsp_o = out_q;

endmodule

FILE: rtl/sorted_line_cache_with_age_expiry.sv
// Top level of the sorted line cache with frame-based age expiry.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on in_valid_i / in_ready_o with in_req_i. A lookup (kind 0)
//   walks the used list in address order and returns a hit, or claims the
//   free head, links it in sorted place and asks for a fill, or reports that
//   no line is free. A frame tick (kind 1) frees every stale line and
//   advances the frame count. One result per request leaves on out_valid_o /
//   out_ready_i with out_rsp_o. stale_frames is written through cfg_we_i /
//   cfg_wdata_i; the user must do so only while idle, as the block does not
//   enforce it.
// Sequencing:
//   All four line memories share one read port, so the walk reads one line
//   at a time; the block takes one request at a time.
// Reset:
//   Lists come back at once (used list empty, free list 0..N-1): link words
//   carry per-entry valid bits, so there is no clearing pass.
// Stall:
//   A finished result waits in the output register; the next request is
//   taken meanwhile and holds in its last step until the register drains.
module sorted_line_cache_with_age_expiry import slcae_pkg::*; #(
  parameter int unsigned NUM_LINES  = NumLinesDef,
  parameter int unsigned LINE_BYTES = LineBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_req_t           in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_rsp_t          out_rsp_o,
  input  logic              cfg_we_i,
  input  logic [StaleW-1:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence walks and link edits
  slcae_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .kind_i     (in_req_i.kind),
    .out_ready_i,
    .status_i   (status),
    .in_ready_o,
    .out_valid_o,
    .cmd_o      (cmd)
  );

  // Hold line memories, list heads and the frame count
  slcae_dp #(
    .NUM_LINES (NUM_LINES),
    .LINE_BYTES(LINE_BYTES)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .in_req_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .status_o   (status),
    .out_rsp_o
  );

endmodule

FILE: rtl/slcae_checker.sv
// Port-level checker for the line cache and its bind statement.
`timescale 1ns / 1ps
`include "sorted_line_cache_with_age_expiry_assert.svh"
module slcae_checker import slcae_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input out_rsp_t out_rsp_i
);

  `SLCAE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `SLCAE_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_rsp_i), "result changed while stalled")
  `SLCAE_ASSERT_NOW(a_hit_no_fill, clk_i, rst_ni, out_valid_i && out_rsp_i.hit, !out_rsp_i.fill_request && !out_rsp_i.no_free_line && (out_rsp_i.released_count == '0), "hit with fill or release")
  `SLCAE_ASSERT_NOW(a_nofree_clean, clk_i, rst_ni, out_valid_i && out_rsp_i.no_free_line, !out_rsp_i.fill_request && (out_rsp_i.line_index == '0) && (out_rsp_i.fill_address == '0), "no free line result not clean")
  `SLCAE_ASSERT_NOW(a_fill_even, clk_i, rst_ni, out_valid_i && out_rsp_i.fill_request, !out_rsp_i.fill_address[0] && (out_rsp_i.line_offset[OffW-1:1] == '0), "fill address odd")

endmodule

bind sorted_line_cache_with_age_expiry slcae_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_i  (out_rsp_o)
);
